// ===== rtl/pbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsm_pkg
// Shared types and constants of the packed-bits to symbol-index mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package pbsm_pkg;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_LENGTH      = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

  localparam logic [3:0] BPS_RESET = 4'd2;

  localparam int ACC_W = 15;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [3:0]       cnt;
    logic [3:0]       bps;
    logic             last;
    logic [1:0]       status;
    logic             marker;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/pbsm_front.sv =====
// ----------------------------------------------------------------------------
// pbsm_front
// Accepts packed bytes, appends their valid bits to the leftover bits and
// hands each byte that yields results or ends a packet to the back end as one job.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsm_front
  import pbsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic [3:0] cfg_data,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic [3:0] bits_in_byte,
  input  wire logic       last_byte,
  output logic            job_push,
  output job_t            job
);

  logic [3:0]       bps;
  logic [6:0]       left_bits;
  logic [2:0]       left_cnt;
  logic [6:0]       left_bits_next;
  logic [2:0]       left_cnt_next;
  logic             supported;
  logic [3:0]       nv;
  logic [7:0]       fresh;
  logic [ACC_W-1:0] acc;
  logic [3:0]       cnt;
  logic [2:0]       rem;
  logic             has_sym;

  always_comb begin
    supported = (bps == 4'd1) || (bps == 4'd2) || (bps == 4'd4) ||
                (bps == 4'd6) || (bps == 4'd8);
    nv    = (bits_in_byte > 4'd8) ? 4'd8 : bits_in_byte;
    fresh = 8'(data_byte >> (4'd8 - nv));
    acc   = (ACC_W'(left_bits) << nv) | ACC_W'(fresh);
    cnt   = {1'b0, left_cnt} + nv;
    unique case (bps)
      4'd2:    rem = {2'b00, cnt[0]};
      4'd4:    rem = {1'b0, cnt[1:0]};
      4'd6:    rem = (cnt >= 4'd12) ? 3'(cnt - 4'd12) :
                     (cnt >= 4'd6)  ? 3'(cnt - 4'd6)  : cnt[2:0];
      4'd8:    rem = cnt[2:0];
      default: rem = 3'd0;
    endcase
    has_sym = cnt >= bps;

    if (!supported || last_byte) begin
      left_bits_next = '0;
      left_cnt_next  = '0;
    end else begin
      left_bits_next = acc[6:0] & 7'((8'd1 << rem) - 8'd1);
      left_cnt_next  = rem;
    end

    job.acc    = acc;
    job.cnt    = cnt;
    job.bps    = bps;
    job.last   = last_byte;
    job.marker = !supported || !has_sym;
    if (!supported) begin
      job.status = STATUS_UNSUPPORTED;
    end else if (rem != 3'd0) begin
      job.status = STATUS_LENGTH;
    end else begin
      job.status = STATUS_OK;
    end
    job_push = accept && (last_byte || (supported && has_sym));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bps       <= BPS_RESET;
      left_bits <= '0;
      left_cnt  <= '0;
    end else begin
      if (cfg_valid) begin
        bps <= cfg_data;
      end
      if (accept) begin
        left_bits <= left_bits_next;
        left_cnt  <= left_cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbsm_queue.sv =====
// ----------------------------------------------------------------------------
// pbsm_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsm_queue
  import pbsm_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      full,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbsm_back.sv =====
// ----------------------------------------------------------------------------
// pbsm_back
// Cuts each job into registered symbol indices, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsm_back
  import pbsm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  job_t       head_job,
  input  wire logic  q_empty,
  output logic       q_pop,
  input  wire logic  pop,
  output logic       empty,
  output logic [7:0] symbol_index,
  output logic       symbol_valid,
  output logic       last_symbol,
  output logic [1:0] status
);

  job_t             cur;
  logic             busy;
  logic             out_valid;
  logic             advance;
  logic             emit;
  logic             fin;
  logic             load;
  logic [3:0]       sh;
  logic [3:0]       cnt_next;
  logic [ACC_W-1:0] shifted;
  logic [ACC_W-1:0] mask;
  logic [7:0]       sym;

  always_comb begin
    advance  = !out_valid || pop;
    emit     = busy && advance;
    sh       = cur.cnt - cur.bps;
    cnt_next = sh;
    shifted  = cur.acc >> sh;
    mask     = ACC_W'((16'd1 << cur.bps) - 16'd1);
    sym      = shifted[7:0] & mask[7:0];
    fin      = cur.marker || (cnt_next < cur.bps);
    load     = advance && (!busy || fin);
    q_pop    = load && !q_empty;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head_job;
    end else if (emit) begin
      cur.cnt <= cnt_next;
    end
    if (emit) begin
      symbol_index <= cur.marker ? 8'd0 : sym;
      symbol_valid <= !cur.marker;
      last_symbol  <= fin && cur.last;
      status       <= (fin && cur.last) ? cur.status : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= !q_empty;
      end
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/packed_bits_to_symbol_index_mapper_top.sv =====
// ----------------------------------------------------------------------------
// packed_bits_to_symbol_index_mapper_top
// Cuts packed packet bytes into 1, 2, 4, 6 or 8 bit symbol indices.
//
//   Channel   Handshake            Payload
//   input     push / full          data_byte, bits_in_byte, last_byte
//   result    pop / empty          symbol_index, symbol_valid, last_symbol,
//                                  status
//   config    cfg_valid/cfg_ready  cfg_data (bits per symbol)
//
// The back end gives one result per cycle while results are popped; a byte
// yields eight results at one bit per symbol, more only right after a size
// change, or one for a marker. The first result of a byte passes the job
// queue, the back end's job register and the output register. The job queue
// of JOB_DEPTH entries lets input run ahead while results stall. Reset clears
// the leftover bits and sets the symbol size to two bits.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_bits_to_symbol_index_mapper_top
  import pbsm_pkg::*;
#(
  parameter int JOB_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic [3:0] bits_in_byte,
  input  wire logic       last_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      symbol_index,
  output logic            symbol_valid,
  output logic            last_symbol,
  output logic [1:0]      status,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data
);

  job_t front_job;
  job_t head_job;
  logic job_push;
  logic q_pop;
  logic q_empty;
  logic accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  pbsm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .data_byte    (data_byte),
    .bits_in_byte (bits_in_byte),
    .last_byte    (last_byte),
    .job_push     (job_push),
    .job          (front_job)
  );

  pbsm_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (full),
    .empty    (q_empty)
  );

  pbsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_job     (head_job),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .symbol_index (symbol_index),
    .symbol_valid (symbol_valid),
    .last_symbol  (last_symbol),
    .status       (status)
  );

endmodule

`default_nettype wire

// ===== tb/pbsm_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsm_scoreboard_pkg
// Predicts the symbol indices that the mapper cuts from each accepted byte
// and checks every popped result against the oldest prediction.
// ----------------------------------------------------------------------------
package pbsm_scoreboard_pkg;

  import pbsm_pkg::*;

  typedef struct packed {
    logic [7:0] index;
    logic       valid;
    logic       last;
    logic [1:0] status;
  } symbol_t;

  class symbol_scoreboard;
    logic [3:0]  size;
    int unsigned held_bits;
    int unsigned held_count;
    symbol_t     expected_q[$];
    int          mismatches;

    function new();
      size       = BPS_RESET;
      held_bits  = 0;
      held_count = 0;
      mismatches = 0;
    endfunction

    function void set_size(logic [3:0] value);
      size = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit size_supported();
      return size == 4'd1 || size == 4'd2 || size == 4'd4 || size == 4'd6 ||
             size == 4'd8;
    endfunction

    function symbol_t make_symbol(int unsigned index, logic valid);
      symbol_t sym;
      sym.index  = index[7:0];
      sym.valid  = valid;
      sym.last   = 1'b0;
      sym.status = STATUS_OK;
      return sym;
    endfunction

    function string describe(symbol_t sym);
      return $sformatf("index %02h valid %0b last %0b status %0d",
                       sym.index, sym.valid, sym.last, sym.status);
    endfunction

    function void note_byte(logic [7:0] data, logic [3:0] nbits, logic is_last);
      symbol_t     produced[$];
      symbol_t     sym;
      int unsigned acc;
      int unsigned cnt;
      int unsigned take;
      int unsigned width;
      int          tail;
      width = 32'(size);
      if (!size_supported()) begin
        held_bits  = 0;
        held_count = 0;
        if (is_last) begin
          sym        = make_symbol(0, 1'b0);
          sym.last   = 1'b1;
          sym.status = STATUS_UNSUPPORTED;
          expected_q.push_back(sym);
        end
        return;
      end
      take = (nbits > 4'd8) ? 8 : 32'(nbits);
      acc  = held_bits;
      cnt  = held_count;
      if (take > 0) begin
        acc = (acc << take) | (int'(data) >> (8 - take));
        cnt = cnt + take;
      end
      while (cnt >= width) begin
        cnt = cnt - width;
        produced.push_back(make_symbol((acc >> cnt) & ((1 << width) - 1), 1'b1));
        acc = acc & ((1 << cnt) - 1);
      end
      if (is_last) begin
        if (produced.size() == 0) begin
          produced.push_back(make_symbol(0, 1'b0));
        end
        tail = produced.size() - 1;
        produced[tail].last   = 1'b1;
        produced[tail].status = (cnt != 0) ? STATUS_LENGTH : STATUS_OK;
        held_bits  = 0;
        held_count = 0;
      end else begin
        held_bits  = acc;
        held_count = cnt;
      end
      foreach (produced[i]) begin
        expected_q.push_back(produced[i]);
      end
    endfunction

    function void check_symbol(symbol_t got);
      symbol_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: %s.", describe(got));
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.index !== want.index || got.valid !== want.valid ||
          got.last !== want.last || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected %s, got %s.", describe(want), describe(got));
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives packed packet bytes into the symbol-index mapper under several
// symbol sizes, with random gaps and stalls on both queue sides, and checks
// each result transaction against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import pbsm_pkg::*;
  import pbsm_scoreboard_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 23;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       push         = 1'b0;
  logic [7:0] data_byte    = 8'd0;
  logic [3:0] bits_in_byte = 4'd0;
  logic       last_byte    = 1'b0;
  logic       pop          = 1'b0;
  logic       cfg_valid    = 1'b0;
  logic [3:0] cfg_data     = 4'd0;
  logic       full;
  logic       empty;
  logic [7:0] symbol_index;
  logic       symbol_valid;
  logic       last_symbol;
  logic [1:0] status;
  logic       cfg_ready;

  bit quiet   = 1'b0;
  bit hold_rx = 1'b0;

  symbol_scoreboard sb = new();

  packed_bits_to_symbol_index_mapper_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .bits_in_byte (bits_in_byte),
    .last_byte    (last_byte),
    .empty        (empty),
    .pop          (pop),
    .symbol_index (symbol_index),
    .symbol_valid (symbol_valid),
    .last_symbol  (last_symbol),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_size(cfg_data);
      end
      if (push && !full) begin
        sb.note_byte(data_byte, bits_in_byte, last_byte);
      end
      if (pop && !empty) begin
        sb.check_symbol('{symbol_index, symbol_valid, last_symbol, status});
      end
    end
  end

  always begin
    @(posedge clk);
    if (hold_rx) begin
      hold_rx = 1'b0;
      pop <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
    end else begin
      pop <= quiet || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic send_byte(logic [7:0] data, logic [3:0] nbits, logic is_last);
    push         <= 1'b1;
    data_byte    <= data;
    bits_in_byte <= nbits;
    last_byte    <= is_last;
    do @(posedge clk); while (full);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic       is_last;
    logic [3:0] nbits;
    is_last = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 9) == 0) begin
      nbits = 4'($urandom_range(0, 15));
    end else if (is_last) begin
      nbits = 4'($urandom_range(1, 8));
    end else begin
      nbits = 4'd8;
    end
    send_byte(8'($urandom_range(0, 255)), nbits, is_last);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [3:0] sizes[14] = '{4'd1, 4'd8, 4'd2, 4'd6, 4'd4, 4'd0, 4'd6,
                              4'd1, 4'd5, 4'd8, 4'd4, 4'd2, 4'd15, 4'd6};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Two-bit symbols from reset, short and oversized byte lengths.
    send_byte(8'hff, 4'd8, 1'b0);
    send_byte(8'h00, 4'd8, 1'b1);
    send_byte(8'ha5, 4'd3, 1'b0);
    send_byte(8'h5a, 4'd0, 1'b0);
    send_byte(8'hc3, 4'd15, 1'b1);
    send_byte(8'h80, 4'd1, 1'b1);

    write_size(4'd1);
    send_byte(8'h80, 4'd8, 1'b1);
    send_byte(8'h01, 4'd1, 1'b1);

    write_size(4'd8);
    send_byte(8'hff, 4'd8, 1'b0);
    send_byte(8'h00, 4'd4, 1'b1);

    // The symbol size changes while a packet is half done.
    write_size(4'd6);
    send_byte(8'hf0, 4'd8, 1'b0);
    write_size(4'd4);
    send_byte(8'h3c, 4'd8, 1'b1);
    send_byte(8'hab, 4'd8, 1'b1);

    write_size(4'd0);
    send_byte(8'h12, 4'd8, 1'b0);
    send_byte(8'h34, 4'd8, 1'b1);
    write_size(4'd15);
    send_byte(8'h55, 4'd8, 1'b1);
    write_size(4'd3);
    send_byte(8'he7, 4'd8, 1'b0);
    send_byte(8'h18, 4'd2, 1'b1);

    write_size(4'd6);
    send_byte(8'hff, 4'd8, 1'b0);
    send_byte(8'hff, 4'd8, 1'b0);
    send_byte(8'hff, 4'd8, 1'b1);

    foreach (sizes[p]) begin
      write_size(sizes[p]);
      if (p == 0) begin
        hold_rx = 1'b1;
      end
      quiet = (p == 3);
      repeat (PHASE_ITEMS) send_random();
    end
    quiet = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule
